/* rtl/tle_pkg.sv */
package tle_pkg;

  // Width of the cursor and length fields on the result port.
  localparam int unsigned POS_W = 7;

  // Key codes.
  localparam logic [7:0] KEY_BS    = 8'd8;
  localparam logic [7:0] KEY_LF    = 8'd10;
  localparam logic [7:0] KEY_CR    = 8'd13;
  localparam logic [7:0] KEY_ESC   = 8'd27;
  localparam logic [7:0] KEY_DEL   = 8'd127;
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7E;
  localparam logic [7:0] CSI_OPEN  = 8'h5B;
  localparam logic [7:0] CSI_RIGHT = 8'h43;
  localparam logic [7:0] CSI_LEFT  = 8'h44;

  // Escape sequence progress.
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_OPEN = 2'd1;
  localparam logic [1:0] ESC_CSI  = 2'd2;

  // Result kinds.
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_LINE   = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [7:0]       line_byte;
    logic             last;
    logic [POS_W-1:0] cursor;
    logic [POS_W-1:0] length;
  } tle_res_t;

endpackage

/* rtl/tle_ram.sv */
module tle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/tle_ctrl.sv */
module tle_ctrl import tle_pkg::*; #(
  parameter int unsigned LINE_CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] rx_byte,
  output logic       busy,
  input  logic       slot_free,
  output logic       res_valid,
  output tle_res_t   res
);

  localparam int unsigned CW = $clog2(LINE_CAPACITY + 1);
  localparam int unsigned AW = $clog2(LINE_CAPACITY);
  localparam logic [CW-1:0] CAP = CW'(LINE_CAPACITY);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SHR_RD   = 4'd1;
  localparam logic [3:0] S_SHR_WR   = 4'd2;
  localparam logic [3:0] S_INS      = 4'd3;
  localparam logic [3:0] S_SHL_RD   = 4'd4;
  localparam logic [3:0] S_SHL_WR   = 4'd5;
  localparam logic [3:0] S_STATUS   = 4'd6;
  localparam logic [3:0] S_EMPTY    = 4'd7;
  localparam logic [3:0] S_EMIT_RD  = 4'd8;
  localparam logic [3:0] S_EMIT_OUT = 4'd9;

  logic [3:0]    state, state_next;
  logic [CW-1:0] cursor, cursor_next;
  logic [CW-1:0] length, length_next;
  logic [1:0]    esc, esc_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [7:0]    key, key_next;
  logic [CW-1:0] ptr_inc, ptr_dec;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  tle_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_line_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign ptr_inc = ptr + 1'b1;
  assign ptr_dec = ptr - 1'b1;
  assign busy    = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cursor_next = cursor;
    length_next = length;
    esc_next    = esc;
    ptr_next    = ptr;
    key_next    = key;
    we          = 1'b0;
    waddr       = ptr[AW-1:0];
    wdata       = rdata;
    re          = 1'b0;
    raddr       = ptr[AW-1:0];
    res_valid   = 1'b0;
    res         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          key_next = rx_byte;
          if (esc == ESC_OPEN) begin
            if (rx_byte == CSI_OPEN) begin
              esc_next = ESC_CSI;
            end else begin
              esc_next   = ESC_NONE;
              state_next = S_STATUS;
            end
          end else if (esc == ESC_CSI) begin
            esc_next   = ESC_NONE;
            state_next = S_STATUS;
            if (rx_byte == CSI_RIGHT && cursor < length) begin
              cursor_next = cursor + 1'b1;
            end else if (rx_byte == CSI_LEFT && cursor != '0) begin
              cursor_next = cursor - 1'b1;
            end
          end else if (rx_byte == KEY_ESC) begin
            esc_next = ESC_OPEN;
          end else if (rx_byte >= PRINT_LO && rx_byte <= PRINT_HI) begin
            ptr_next   = length;
            state_next = (length < CAP) ? S_SHR_RD : S_STATUS;
          end else if (rx_byte == KEY_BS || rx_byte == KEY_DEL) begin
            if (cursor != '0 && length != '0) begin
              cursor_next = cursor - 1'b1;
              ptr_next    = cursor - 1'b1;
              state_next  = S_SHL_RD;
            end else begin
              state_next = S_STATUS;
            end
          end else if (rx_byte == KEY_CR || rx_byte == KEY_LF) begin
            ptr_next   = '0;
            state_next = (length == '0) ? S_EMPTY : S_EMIT_RD;
          end else begin
            state_next = S_STATUS;
          end
        end
      end
      // Move the tail right, highest entry first.
      S_SHR_RD: begin
        if (ptr == cursor) begin
          state_next = S_INS;
        end else begin
          re         = 1'b1;
          raddr      = ptr_dec[AW-1:0];
          state_next = S_SHR_WR;
        end
      end
      S_SHR_WR: begin
        we         = 1'b1;
        waddr      = ptr[AW-1:0];
        wdata      = rdata;
        ptr_next   = ptr_dec;
        state_next = S_SHR_RD;
      end
      S_INS: begin
        we          = 1'b1;
        waddr       = cursor[AW-1:0];
        wdata       = key;
        cursor_next = cursor + 1'b1;
        length_next = length + 1'b1;
        state_next  = S_STATUS;
      end
      // Move the tail left, lowest entry first.
      S_SHL_RD: begin
        if (ptr_inc >= length) begin
          length_next = length - 1'b1;
          state_next  = S_STATUS;
        end else begin
          re         = 1'b1;
          raddr      = ptr_inc[AW-1:0];
          state_next = S_SHL_WR;
        end
      end
      S_SHL_WR: begin
        we         = 1'b1;
        waddr      = ptr[AW-1:0];
        wdata      = rdata;
        ptr_next   = ptr_inc;
        state_next = S_SHL_RD;
      end
      S_STATUS: begin
        if (slot_free) begin
          res_valid      = 1'b1;
          res.kind       = KIND_STATUS;
          res.last       = 1'b1;
          res.cursor     = POS_W'(cursor);
          res.length     = POS_W'(length);
          state_next     = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (slot_free) begin
          res_valid  = 1'b1;
          res.kind   = KIND_LINE;
          res.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        re         = 1'b1;
        raddr      = ptr[AW-1:0];
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (slot_free) begin
          res_valid     = 1'b1;
          res.kind      = KIND_LINE;
          res.line_byte = rdata;
          res.last      = (ptr_inc == length);
          res.length    = POS_W'(length);
          if (ptr_inc == length) begin
            cursor_next = '0;
            length_next = '0;
            state_next  = S_IDLE;
          end else begin
            ptr_next   = ptr_inc;
            state_next = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cursor <= '0;
      length <= '0;
      esc    <= ESC_NONE;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      length <= length_next;
      esc    <= esc_next;
    end
    ptr <= ptr_next;
    key <= key_next;
  end

endmodule

/* rtl/terminal_line_editor_top.sv */
// Line editor for received terminal bytes.
// Input channel: one byte per request on rx_byte, qualified by in_valid; the
// block holds in_stall high while it is working on a byte. Output channel: one
// result per request on kind, line_byte, last, cursor_out and length_out,
// qualified by out_valid; the receiver holds a result with out_stall.
// The line itself lives in a single-port-write, single-port-read RAM with a
// registered read; edits are read-modify-write sweeps over it.
// Steps per byte: a status key (cursor move, ignored byte) goes through the
// status state; ESC and the '[' after it produce no result. An insert and a
// delete shift the tail through the RAM by a read and a write per entry; then
// the insert writes the key at the cursor, and both report their status.
// CR or LF streams the line out one character at a time (RAM read, then
// output), or gives one empty-line marker.
// Results pass through a single output register, so the next byte may be
// taken while the last result still waits; a stalled receiver holds that
// register and, once the engine has its next result ready, the engine too.
// Synchronous reset empties the line, parks the cursor at 0, drops any
// pending escape sequence and marks the output register empty. RAM contents are
// not cleared; only entries below the current length are ever read.
module terminal_line_editor_top import tle_pkg::*; #(
  parameter int unsigned LINE_CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       rx_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             kind,
  output logic [7:0]       line_byte,
  output logic             last,
  output logic [POS_W-1:0] cursor_out,
  output logic [POS_W-1:0] length_out
);

  logic     busy;
  logic     slot_free;
  logic     res_valid;
  tle_res_t res;
  tle_res_t out_reg;

  // The output register may take a new result when it is empty or being
  // drained in this cycle.
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = busy;

  tle_ctrl #(.LINE_CAPACITY(LINE_CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .rx_byte   (rx_byte),
    .busy      (busy),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= res_valid;
    end
    if (slot_free && res_valid) begin
      out_reg <= res;
    end
  end

  assign kind       = out_reg.kind;
  assign line_byte  = out_reg.line_byte;
  assign last       = out_reg.last;
  assign cursor_out = out_reg.cursor;
  assign length_out = out_reg.length;

endmodule

/* rtl/tle_checker.sv */
module tle_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       kind,
  input logic [7:0] line_byte,
  input logic       last,
  input logic [6:0] cursor_out,
  input logic [6:0] length_out
);

  // A held result keeps its kind, byte, last flag and length.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(line_byte) && $stable(kind)
      && $stable(last) && $stable(length_out))
    else $error("stalled result changed");

  // A status result closes its run, carries no character and a cursor inside the line.
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> last && line_byte == 8'd0 && cursor_out <= length_out)
    else $error("bad status result");

  // Line bytes report the cursor as parked at the start.
  a_line_cursor: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> cursor_out == 7'd0)
    else $error("line result with nonzero cursor");

  // A line byte that is not the last one belongs to a non-empty line.
  a_line_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind && !last |-> length_out != 7'd0)
    else $error("multi-byte run with zero length");

  // Reset leaves the input side ready and no result on offer.
  a_reset: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

endmodule

bind terminal_line_editor_top tle_checker u_tle_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .kind       (kind),
  .line_byte  (line_byte),
  .last       (last),
  .cursor_out (cursor_out),
  .length_out (length_out)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import tle_pkg::*;

  // Line size of the block under test. The checker keeps its own copy of the line at
  // this size.
  localparam int unsigned TEXT_CAP = 64;

  // The run stops here if it hangs. A correct run needs only a small part of this.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // Cycles to keep watching the result port after the last expected result. This
  // covers the longest edit sweep with room to spare.
  localparam int unsigned SETTLE_CYCLES = 200;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  kind;
  logic [7:0]            line_byte;
  logic                  last;
  logic [POS_W-1:0]      cursor_out;
  logic [POS_W-1:0]      length_out;

  terminal_line_editor_top #(
    .LINE_CAPACITY(TEXT_CAP)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .line_byte  (line_byte),
    .last       (last),
    .cursor_out (cursor_out),
    .length_out (length_out)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Keystrokes wait here until the driver offers them as requests. Results that the
  // checker's own copy of the editor has worked out wait in due_results, oldest first.
  logic [7:0]  keystrokes [$];
  tle_res_t    due_results [$];

  // Chance, in percent, that the sender holds back a request or the receiver stalls in
  // a given cycle. The stimulus process changes these between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned failures = 0;
  int unsigned keys_sent = 0;
  int unsigned results_checked = 0;
  int unsigned lines_checked = 0;
  int unsigned cycle_count = 0;

  // The checker's own copy of the editor state: the text, the cursor, the length and
  // how far an escape sequence has got.
  logic [7:0]       mirror_text [TEXT_CAP];
  logic [POS_W-1:0] mirror_cursor = '0;
  logic [POS_W-1:0] mirror_len = '0;
  logic [1:0]       mirror_esc = ESC_NONE;

  logic [7:0] opening_keys [24];
  tle_res_t   head_result;

  // Apply one accepted keystroke to the local copy of the editor, and queue every
  // result that the keystroke should cause.
  task automatic apply_keystroke(input logic [7:0] key);
    bit       report_status;
    tle_res_t res;
    report_status = 1'b1;
    case (mirror_esc)
      ESC_OPEN: begin
        // After ESC, only '[' keeps the sequence going. Any other byte is swallowed,
        // and the block still reports its status.
        if (key == CSI_OPEN) begin
          mirror_esc = ESC_CSI;
          report_status = 1'b0;
        end else begin
          mirror_esc = ESC_NONE;
        end
      end
      ESC_CSI: begin
        // This is the final byte of the sequence. C and D move the cursor, held
        // within the line. Any other final byte is swallowed.
        mirror_esc = ESC_NONE;
        if (key == CSI_RIGHT && mirror_cursor < mirror_len) begin
          mirror_cursor++;
        end else if (key == CSI_LEFT && mirror_cursor != 0) begin
          mirror_cursor--;
        end
      end
      default: begin
        if (key == KEY_ESC) begin
          mirror_esc = ESC_OPEN;
          report_status = 1'b0;
        end else if (key >= PRINT_LO && key <= PRINT_HI) begin
          // Insert at the cursor and push the rest of the line one place right. The
          // byte is dropped when the line is already full.
          if (mirror_len < TEXT_CAP) begin
            for (int i = mirror_len; i > mirror_cursor; i--) begin
              mirror_text[i] = mirror_text[i-1];
            end
            mirror_text[mirror_cursor] = key;
            mirror_cursor++;
            mirror_len++;
          end
        end else if (key == KEY_BS || key == KEY_DEL) begin
          // Remove the character before the cursor and pull the rest of the line one
          // place left.
          if (mirror_cursor != 0) begin
            mirror_cursor--;
            for (int i = mirror_cursor; i + 1 < mirror_len; i++) begin
              mirror_text[i] = mirror_text[i+1];
            end
            mirror_len--;
          end
        end else if (key == KEY_CR || key == KEY_LF) begin
          // Send out the finished line, one result per character. An empty line sends
          // a single marker instead. The line then starts over.
          report_status = 1'b0;
          if (mirror_len == 0) begin
            res = '{kind: KIND_LINE, line_byte: 8'h00, last: 1'b1, cursor: '0, length: '0};
            due_results.push_back(res);
          end else begin
            for (int i = 0; i < mirror_len; i++) begin
              res = '{kind: KIND_LINE, line_byte: mirror_text[i],
                      last: (i == mirror_len - 1), cursor: '0, length: mirror_len};
              due_results.push_back(res);
            end
          end
          mirror_cursor = '0;
          mirror_len = '0;
        end
      end
    endcase
    if (report_status) begin
      res = '{kind: KIND_STATUS, line_byte: 8'h00, last: 1'b1,
              cursor: mirror_cursor, length: mirror_len};
      due_results.push_back(res);
    end
  endtask

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      failures++;
    end
  endtask

  // Driver. The payload on offer stays put until the block takes it. A new request is
  // raised only after the previous one has been taken, or when none is on offer. Each
  // step gives in_valid at most one nonblocking assignment.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte <= 8'h00;
    end else begin
      if (in_valid && !in_stall) begin
        apply_keystroke(rx_byte);
        keys_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (keystrokes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte <= keystrokes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. It sets a new random stall every cycle, and checks each result the
  // receiver takes against the oldest result still due.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d line_byte %0d last %0d cursor %0d length %0d",
                 kind, line_byte, last, cursor_out, length_out);
          failures++;
        end else begin
          head_result = due_results.pop_front();
          compare_field("kind", 8'(head_result.kind), 8'(kind));
          compare_field("line_byte", head_result.line_byte, line_byte);
          compare_field("last", 8'(head_result.last), 8'(last));
          compare_field("cursor_out", 8'(head_result.cursor), 8'(cursor_out));
          compare_field("length_out", 8'(head_result.length), 8'(length_out));
          results_checked++;
          if (head_result.kind == KIND_LINE && head_result.last) begin
            lines_checked++;
          end
        end
      end
    end
  end

  // Watchdog. It stops a run that has hung.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Wait until every request has been taken and every result that was due has come
  // out. Once the queue is empty, the sender sits idle.
  task automatic wait_for_drain();
    while (keystrokes.size() != 0 || in_valid || due_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Queue a burst of mixed typing. Most of it is well-formed editing: text, erasing,
  // arrow keys and Enter. The rest is stray bytes and broken escape sequences.
  task automatic queue_typing_session(input int unsigned target);
    int unsigned queued;
    int unsigned pick;
    queued = 0;
    while (queued < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        repeat ($urandom_range(4, 1)) begin
          keystrokes.push_back(8'($urandom_range(PRINT_HI, PRINT_LO)));
          queued++;
        end
      end else if (pick < 57) begin
        keystrokes.push_back(($urandom_range(1) != 0) ? KEY_DEL : KEY_BS);
        queued++;
      end else if (pick < 69) begin
        keystrokes.push_back(KEY_ESC);
        keystrokes.push_back(CSI_OPEN);
        keystrokes.push_back(($urandom_range(1) != 0) ? CSI_RIGHT : CSI_LEFT);
        queued += 3;
      end else if (pick < 77) begin
        keystrokes.push_back(($urandom_range(1) != 0) ? KEY_CR : KEY_LF);
        queued++;
      end else if (pick < 85) begin
        keystrokes.push_back(8'($urandom_range(255)));
        queued++;
      end else if (pick < 92) begin
        keystrokes.push_back(KEY_ESC);
        keystrokes.push_back(8'($urandom_range(255)));
        queued += 2;
      end else begin
        keystrokes.push_back(KEY_ESC);
        keystrokes.push_back(CSI_OPEN);
        keystrokes.push_back(8'($urandom_range(255)));
        queued += 3;
      end
    end
  endtask

  initial begin
    // The opening keys go after the corner cases one by one. They cover Enter on an
    // empty line, erasing at the start of the line, arrow keys at both ends, the
    // lowest and highest printable bytes, an insert and a delete in the middle of the
    // line, a broken escape sequence after ESC and after ESC '[', ESC while a sequence
    // is pending, and a high byte that is ignored.
    opening_keys = '{KEY_CR, KEY_BS,
                     KEY_ESC, CSI_OPEN, CSI_LEFT,
                     PRINT_LO, PRINT_HI,
                     KEY_ESC, CSI_OPEN, CSI_RIGHT,
                     KEY_ESC, CSI_OPEN, CSI_LEFT,
                     8'h58, KEY_DEL,
                     KEY_ESC, 8'h78,
                     KEY_ESC, CSI_OPEN, 8'h5A,
                     KEY_ESC, KEY_ESC,
                     8'h80, KEY_LF};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Phase one: the sender idles often, and the receiver idles most of the time.
    send_idle_pct = 36;
    recv_idle_pct = 70;
    foreach (opening_keys[i]) begin
      keystrokes.push_back(opening_keys[i]);
    end
    // Fill the line past its capacity, so the last printable bytes are dropped. Then
    // step back, erase and type again inside the full line, and send all of it.
    keystrokes.push_back(KEY_CR);
    repeat (TEXT_CAP + 2) begin
      keystrokes.push_back(8'($urandom_range(PRINT_HI, PRINT_LO)));
    end
    keystrokes.push_back(KEY_ESC);
    keystrokes.push_back(CSI_OPEN);
    keystrokes.push_back(CSI_LEFT);
    keystrokes.push_back(KEY_BS);
    keystrokes.push_back(8'h5A);
    keystrokes.push_back(KEY_CR);
    queue_typing_session(35);
    wait_for_drain();

    // Phase two: the idle rates are swapped. Phase three: neither side idles.
    send_idle_pct = 70;
    recv_idle_pct = 36;
    queue_typing_session(35);
    wait_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_typing_session(35);
    wait_for_drain();

    // Keep watching for stray results once nothing more is due.
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Typed %0d keys through three stall mixes and matched %0d results,",
             keys_sent, results_checked);
    $display("including %0d completed lines and one line filled past capacity.",
             lines_checked);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* terminal_line_editor_top.f */
rtl/tle_pkg.sv
rtl/tle_ram.sv
rtl/tle_ctrl.sv
rtl/terminal_line_editor_top.sv
rtl/tle_checker.sv
dv/tb_top.sv
